// ===== sv/tmhq_pkg.sv =====
// ============================================================================
// tmhq_pkg
// Shared types and constants of the timer min-heap queue.
// ============================================================================
package tmhq_pkg;

    localparam int HEAP_DEPTH_DEF = 64;
    localparam int OWNER_BITS_DEF = 16;
    localparam int DL_W           = 64;
    localparam int OWN_W          = 16;
    localparam int SLOT_W         = 7;
    localparam int WAIT_W         = 31;
    localparam int KIND_W         = 3;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_POP    = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SLOT    = 3'd0,
        KIND_POPPED  = 3'd1,
        KIND_TIMEOUT = 3'd2,
        KIND_EMPTY   = 3'd3,
        KIND_FULL    = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_HOLE,
        ST_WT_HOLE,
        ST_RD_LAST,
        ST_WT_LAST,
        ST_DECIDE,
        ST_UP_RD,
        ST_UP_WT,
        ST_UP_CMP,
        ST_DN_RDL,
        ST_DN_RDR,
        ST_DN_WT,
        ST_DN_CMP,
        ST_PLACE,
        ST_OUT
    } state_t;

    // result request handed from the sequencer to the output stage
    typedef struct packed {
        kind_t               kind;
        logic [OWN_W-1:0]    owner;
        logic [SLOT_W-1:0]   slot;
        logic [WAIT_W-1:0]   wait_ms;
        logic                last;
    } res_t;

endpackage

// ===== sv/timer_min_heap_queue_core.sv =====
// ============================================================================
// timer_min_heap_queue_core
// Timer queue kept as a binary min-heap ordered by deadline.
// ============================================================================
// One request at a time: a request walks a single heap path on the entry
// memory (registered read) with a shared less-than deadline comparator. An
// add moves the entry up, a remove moves it up or down and a pop moves it
// down; a stall on the result side holds the walk. Every entry move is
// reported as a result; the final result of a request carries tlast. No
// clearing pass is needed.
module timer_min_heap_queue_core #(
    parameter int HEAP_DEPTH = tmhq_pkg::HEAP_DEPTH_DEF,
    parameter int OWNER_BITS = tmhq_pkg::OWNER_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // action[1:0], deadline[65:2], owner[81:66], slot_ref[88:82], now_ms[152:89]
    input  logic [159:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // owner_out[15:0], new_slot[22:16], wait_ms[53:23]
    output logic [55:0]  m_tdata,
    // kind[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);
    import tmhq_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    logic [DL_W-1:0]   wdl, rdl;
    logic [OWNER_BITS-1:0] wown, rown;
    res_t              res;
    logic              res_valid, res_ready;

    tmhq_seq #(.DEPTH(HEAP_DEPTH), .OWNB(OWNER_BITS)) u_seq (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_action(action_t'(s_tdata[1:0])),
        .in_deadline(s_tdata[65:2]),
        .in_owner(OWNER_BITS'(s_tdata[81:66])),
        .in_slot_ref(s_tdata[88:82]),
        .in_now(s_tdata[152:89]),
        .mem_we(we), .mem_waddr(waddr), .mem_wdl(wdl), .mem_wown(wown),
        .mem_raddr(raddr), .mem_rdl(rdl), .mem_rown(rown),
        .res, .res_valid, .res_ready
    );

    tmhq_store #(.DEPTH(HEAP_DEPTH), .OWNB(OWNER_BITS)) u_store (
        .aclk, .we, .waddr, .wdl, .wown, .raddr, .rdl, .rown
    );

    tmhq_out u_out (
        .aclk, .aresetn, .res_in(res), .res_valid, .res_ready,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
    );
endmodule

// ===== sv/tmhq_store.sv =====
// ============================================================================
// tmhq_store
// Heap entry memory: one write port and one registered read port.
// ============================================================================
module tmhq_store #(
    parameter int DEPTH = tmhq_pkg::HEAP_DEPTH_DEF,
    parameter int OWNB  = tmhq_pkg::OWNER_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [tmhq_pkg::DL_W-1:0] wdl,
    input  logic [OWNB-1:0]          wown,
    input  logic [AW-1:0]            raddr,
    output logic [tmhq_pkg::DL_W-1:0] rdl,
    output logic [OWNB-1:0]          rown
);
    import tmhq_pkg::*;

    logic [DL_W+OWNB-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= {wdl, wown};
        end
        {rdl, rown} <= mem[raddr];
    end
endmodule

// ===== sv/tmhq_out.sv =====
// ============================================================================
// tmhq_out
// Result register: holds one result request until the sink takes it.
// ============================================================================
module tmhq_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tmhq_pkg::res_t       res_in,
    input  logic                 res_valid,
    output logic                 res_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [55:0]          m_tdata,
    output logic [2:0]           m_tuser,
    output logic                 m_tlast
);
    import tmhq_pkg::*;

    res_t res_reg;
    logic valid_reg;

    assign res_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (res_ready) begin
            valid_reg <= res_valid;
        end
        if (res_ready && res_valid) begin
            res_reg <= res_in;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = res_reg.kind;
    assign m_tdata  = {2'b00, res_reg.wait_ms, res_reg.slot, res_reg.owner};
    assign m_tlast  = res_reg.last;
endmodule

// ===== sv/tmhq_seq.sv =====
// ============================================================================
// tmhq_seq
// Heap sequencer: walks one heap path per request with a shared compare.
// ============================================================================
module tmhq_seq #(
    parameter int DEPTH = tmhq_pkg::HEAP_DEPTH_DEF,
    parameter int OWNB  = tmhq_pkg::OWNER_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  tmhq_pkg::action_t         in_action,
    input  logic [tmhq_pkg::DL_W-1:0] in_deadline,
    input  logic [OWNB-1:0]           in_owner,
    input  logic [tmhq_pkg::SLOT_W-1:0] in_slot_ref,
    input  logic [tmhq_pkg::DL_W-1:0] in_now,
    output logic                      mem_we,
    output logic [AW-1:0]             mem_waddr,
    output logic [tmhq_pkg::DL_W-1:0] mem_wdl,
    output logic [OWNB-1:0]           mem_wown,
    output logic [AW-1:0]             mem_raddr,
    input  logic [tmhq_pkg::DL_W-1:0] mem_rdl,
    input  logic [OWNB-1:0]           mem_rown,
    output tmhq_pkg::res_t            res,
    output logic                      res_valid,
    input  logic                      res_ready
);
    import tmhq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    action_t             act_reg;
    logic [DL_W-1:0]     now_reg;
    logic [DL_W-1:0]     dl_reg, dl_next;        // moving entry
    logic [OWNB-1:0]     own_reg, own_next;
    logic [DL_W-1:0]     od_reg, od_next;        // removed deadline
    logic [DL_W-1:0]     cd_reg, cd_next;        // best child / parent
    logic [OWNB-1:0]     co_reg, co_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic [CW-1:0]       cix_reg, cix_next;
    res_t                pend_reg, pend_next;

    // shared comparator: a < b
    logic [DL_W-1:0] cmp_a, cmp_b;
    logic            cmp_lt;
    assign cmp_lt = cmp_a < cmp_b;

    logic [CW-1:0] par_ix, lchild, rchild;
    logic [CW:0]   lchild_w;
    assign par_ix   = (pos_reg - CW'(1)) >> 1;
    assign lchild_w = {pos_reg, 1'b1};
    assign lchild   = lchild_w[CW-1:0];
    assign rchild   = lchild + CW'(1);
    logic lchild_in, rchild_in;
    assign lchild_in = lchild_w < (CW+1)'(count_reg);
    assign rchild_in = lchild_w + (CW+1)'(1) < (CW+1)'(count_reg);

    logic [DL_W-1:0] diff;
    assign diff = mem_rdl - now_reg;

    function automatic res_t mk(kind_t k, logic [OWNB-1:0] o, logic [CW-1:0] s,
                                logic [WAIT_W-1:0] w, logic l);
        res_t r;
        r.kind    = k;
        r.owner   = OWN_W'(o);
        r.slot    = SLOT_W'(s);
        r.wait_ms = w;
        r.last    = l;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
        if (in_valid && in_ready) begin
            act_reg <= in_action;
            now_reg <= in_now;
        end
        dl_reg       <= dl_next;
        own_reg      <= own_next;
        od_reg       <= od_next;
        cd_reg       <= cd_next;
        co_reg       <= co_next;
        pos_reg      <= pos_next;
        cix_reg      <= cix_next;
        pend_reg     <= pend_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dl_next       = dl_reg;
        own_next      = own_reg;
        od_next       = od_reg;
        cd_next       = cd_reg;
        co_next       = co_reg;
        pos_next      = pos_reg;
        cix_next      = cix_reg;
        pend_next     = pend_reg;
        mem_we        = 1'b0;
        mem_waddr     = AW'(pos_reg);
        mem_wdl       = dl_reg;
        mem_wown      = own_reg;
        mem_raddr     = '0;
        cmp_a         = dl_reg;
        cmp_b         = cd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    unique case (in_action)
                        ACT_ADD: begin
                            if (count_reg == CW'(DEPTH)) begin
                                pend_next = mk(KIND_FULL, in_owner, '0, '0, 1'b1);
                                state_next = ST_OUT;
                            end else begin
                                dl_next    = in_deadline;
                                own_next   = in_owner;
                                pos_next   = count_reg;
                                count_next = count_reg + CW'(1);
                                state_next = ST_UP_RD;
                            end
                        end
                        ACT_REMOVE: begin
                            if (in_slot_ref == '0 ||
                                {1'b0, in_slot_ref} > (SLOT_W+1)'(count_reg)) begin
                                pend_next = mk(KIND_EMPTY, '0, '0, '0, 1'b1);
                                state_next = ST_OUT;
                            end else begin
                                pos_next   = CW'(in_slot_ref - SLOT_W'(1));
                                state_next = ST_RD_HOLE;
                            end
                        end
                        default: begin
                            if (count_reg == '0) begin
                                pend_next = mk(KIND_EMPTY, '0, '0, '0, 1'b1);
                                state_next = ST_OUT;
                            end else begin
                                pos_next   = '0;
                                state_next = ST_RD_HOLE;
                            end
                        end
                    endcase
                end
            end
            ST_RD_HOLE: begin
                mem_raddr  = AW'(pos_reg);
                state_next = ST_WT_HOLE;
            end
            ST_WT_HOLE: begin
                mem_raddr = AW'(count_reg - CW'(1));
                od_next   = mem_rdl;
                if (act_reg == ACT_QUERY) begin
                    if (mem_rdl > now_reg) begin
                        pend_next = mk(KIND_TIMEOUT, mem_rown, CW'(1),
                                       (diff[DL_W-1:WAIT_W] != '0) ? '1
                                                                   : diff[WAIT_W-1:0], 1'b1);
                    end else begin
                        pend_next = mk(KIND_TIMEOUT, mem_rown, CW'(1), '0, 1'b1);
                    end
                    state_next = ST_OUT;
                end else begin
                    // report the leaving owner, then fetch the last entry
                    pend_next = mk((act_reg == ACT_POP) ? KIND_POPPED : KIND_SLOT,
                                   mem_rown, '0, '0,
                                   pos_reg == count_reg - CW'(1));
                    count_next = count_reg - CW'(1);
                    state_next = ST_RD_LAST;
                end
            end
            ST_RD_LAST: begin
                // last entry lands now; hold it as the moving entry
                dl_next    = mem_rdl;
                own_next   = mem_rown;
                state_next = ST_WT_LAST;
            end
            ST_WT_LAST: begin
                if (res_ready) begin
                    state_next = pend_reg.last ? ST_IDLE : ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cmp_a = dl_reg;
                cmp_b = od_reg;
                if (act_reg == ACT_POP) begin
                    state_next = ST_DN_RDL;
                end else if (cmp_lt) begin
                    state_next = ST_UP_RD;
                end else if (dl_reg == od_reg) begin
                    state_next = ST_PLACE;
                end else begin
                    state_next = ST_DN_RDL;
                end
            end
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    state_next = ST_PLACE;
                end else begin
                    mem_raddr  = AW'(par_ix);
                    state_next = ST_UP_WT;
                end
            end
            ST_UP_WT: begin
                cd_next    = mem_rdl;
                co_next    = mem_rown;
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP: begin
                cmp_a = dl_reg;
                cmp_b = cd_reg;
                if (!cmp_lt) begin
                    state_next = ST_PLACE;
                end else if (res_ready) begin
                    // move parent down
                    mem_we    = 1'b1;
                    mem_waddr = AW'(pos_reg);
                    mem_wdl   = cd_reg;
                    mem_wown  = co_reg;
                    pos_next  = par_ix;
                    state_next = ST_UP_RD;
                end
            end
            ST_DN_RDL: begin
                if (!lchild_in) begin
                    state_next = ST_PLACE;
                end else begin
                    mem_raddr  = AW'(lchild);
                    state_next = ST_DN_RDR;
                end
            end
            ST_DN_RDR: begin
                cd_next  = mem_rdl;
                co_next  = mem_rown;
                cix_next = lchild;
                mem_raddr = AW'(rchild);
                state_next = rchild_in ? ST_DN_WT : ST_DN_CMP;
            end
            ST_DN_WT: begin
                cmp_a = cd_reg;
                cmp_b = mem_rdl;
                // right child wins unless the left one is strictly smaller
                if (!cmp_lt) begin
                    cd_next  = mem_rdl;
                    co_next  = mem_rown;
                    cix_next = rchild;
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                cmp_a = cd_reg;
                cmp_b = dl_reg;
                if (!cmp_lt) begin
                    state_next = ST_PLACE;
                end else if (res_ready) begin
                    mem_we    = 1'b1;
                    mem_waddr = AW'(pos_reg);
                    mem_wdl   = cd_reg;
                    mem_wown  = co_reg;
                    pos_next  = cix_reg;
                    state_next = ST_DN_RDL;
                end
            end
            ST_PLACE: begin
                if (res_ready) begin
                    mem_we     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        res = pend_reg;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_WT_LAST, ST_OUT: res_valid = 1'b1;
            ST_UP_CMP, ST_DN_CMP: begin
                res = mk(KIND_SLOT, co_reg, pos_reg + CW'(1), '0, 1'b0);
                res_valid = cmp_lt;
            end
            ST_PLACE: begin
                res = mk(KIND_SLOT, own_reg, pos_reg + CW'(1), '0, 1'b1);
                res_valid = 1'b1;
            end
            default:    res_valid = 1'b0;
        endcase
    end
endmodule

// ===== sv/tmhq_chk.sv =====
// ============================================================================
// tmhq_chk
// Port-level checks of the timer queue.
// ============================================================================
module tmhq_chk (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [55:0]  m_tdata,
    input logic [2:0]   m_tuser,
    input logic         m_tlast
);
    import tmhq_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= KIND_FULL)
        else $error("bad result kind");
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_EMPTY || m_tuser == KIND_FULL ||
                     m_tuser == KIND_TIMEOUT)
        |-> m_tlast)
        else $error("single result without tlast");
endmodule

bind timer_min_heap_queue_core tmhq_chk u_chk (.*);
